// ----- hdl/crc32c_pkg.sv -----
// Shared types, constants and functions for the CRC-32C stream update block.
// Holds the zero-byte advance matrices of the reflected Castagnoli polynomial.
// Depends on nothing.
package crc32c_pkg;

	localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
	localparam int          CRC_W     = 32;
	localparam int          BYTE_W    = 8;
	localparam int          MAX_BYTES = 8;
	localparam int          BYTES_DEF = 8;
	localparam int          CNT_W     = 4;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CRC_W-1:0] crc_t;
	typedef logic [MAX_BYTES:0][CRC_W-1:0][CRC_W-1:0] zcol_t;

	typedef struct packed {
		logic start;
		logic last;
		cnt_t n;
		crc_t seed;
	} s1_t;

	function automatic zcol_t zcol_build();
		zcol_t t;
		crc_t  c;
		for (int j = 0; j <= MAX_BYTES; j++) begin
			for (int i = 0; i < CRC_W; i++) begin
				c = crc_t'(1) << i;
				for (int s = 0; s < BYTE_W * j; s++) begin
					c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
				end
				t[j][i] = c;
			end
		end
		return t;
	endfunction

	localparam zcol_t ZCOL = zcol_build();

	// Advance a CRC through j zero bytes, as a sum of constant matrix columns.
	function automatic crc_t zmul(crc_t x, cnt_t j);
		crc_t r;
		r = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (x[i]) begin
				r = r ^ ZCOL[j][i];
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/crc32c_lane.sv -----
// One byte lane: folds its data byte forward to the end of the request's bytes.
// Uses crc32c_pkg for the advance matrices; output is registered.
module crc32c_lane #(
	parameter int LANE = 0
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [crc32c_pkg::BYTE_W-1:0]       byte_in,
	input  crc32c_pkg::cnt_t                    n,
	output crc32c_pkg::crc_t                    term_s1
);

	crc32c_pkg::crc_t term;

	always_comb begin
		term = '0;
		if (crc32c_pkg::cnt_t'(LANE) < n) begin
			term = crc32c_pkg::zmul({{(crc32c_pkg::CRC_W-crc32c_pkg::BYTE_W){1'b0}}, byte_in},
				crc32c_pkg::cnt_t'(n - crc32c_pkg::cnt_t'(LANE)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1 <= term;
		end
	end

endmodule

// ----- hdl/crc32c_merge.sv -----
// Merge stage: combines the lane terms with the advanced start CRC and holds
// the running CRC, which doubles as the output register. Uses crc32c_pkg.
module crc32c_merge #(
	parameter int BYTES_PER_ITEM = crc32c_pkg::BYTES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    take,
	input  logic                                    out_ready,
	input  crc32c_pkg::s1_t                         s1,
	input  crc32c_pkg::crc_t [BYTES_PER_ITEM-1:0]   lane_terms,
	output logic                                    out_valid,
	output crc32c_pkg::crc_t                        crc_value,
	output logic                                    is_last
);

	crc32c_pkg::crc_t crc_start;
	crc32c_pkg::crc_t crc_next;

	always_comb begin
		crc_start = s1.start ? s1.seed : crc_value;
		crc_next  = crc32c_pkg::zmul(crc_start, s1.n);
		for (int k = 0; k < BYTES_PER_ITEM; k++) begin
			crc_next = crc_next ^ lane_terms[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			crc_value <= '0;
			is_last   <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
			crc_value <= crc_next;
			is_last   <= s1.last;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// ----- hdl/crc32c_stream_update.sv -----
// Top level of the CRC-32C stream update block: byte lanes plus merge stage.
// Depends on crc32c_pkg, crc32c_lane and crc32c_merge.
//
// The block takes a request of up to BYTES_PER_ITEM bytes into the lane
// registers and presents its updated CRC from the merge register. The first
// stage is a row of byte lanes that each carry their byte forward through the
// remaining bytes of the request; the second stage merges the lanes with the
// start CRC in a loop on the running CRC, which sets the rate of one request per
// cycle while the output is not stalled. A new request is also taken while a
// finished result waits if the first stage is empty. The CRC has no pre- or
// post-inversion; a byte count above BYTES_PER_ITEM is taken as BYTES_PER_ITEM.
module crc32c_stream_update #(
	parameter int BYTES_PER_ITEM = crc32c_pkg::BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  valid_bytes,
	input  logic        start_flag,
	input  logic [31:0] seed_value,
	input  logic        last_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] crc_value,
	output logic        is_last
);

	logic                                        s1_valid_q;
	logic                                        out_free;
	logic                                        accept;
	logic                                        take;
	crc32c_pkg::cnt_t                            cnt_sat;
	crc32c_pkg::s1_t                             ctl_s1;
	crc32c_pkg::crc_t [BYTES_PER_ITEM-1:0]       lane_terms;

	assign out_free = !out_valid || out_ready;
	assign in_ready = !s1_valid_q || out_free;
	assign accept   = in_valid && in_ready;
	assign take     = s1_valid_q && out_free;
	assign cnt_sat  = (valid_bytes > crc32c_pkg::cnt_t'(BYTES_PER_ITEM)) ?
		crc32c_pkg::cnt_t'(BYTES_PER_ITEM) : valid_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.start <= start_flag;
			ctl_s1.last  <= last_flag;
			ctl_s1.n     <= cnt_sat;
			ctl_s1.seed  <= seed_value;
		end
	end

	for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
		crc32c_lane #(
			.LANE(k)
		) u_lane (
			.clk     (clk),
			.en      (accept),
			.byte_in (data_bytes[crc32c_pkg::BYTE_W*k +: crc32c_pkg::BYTE_W]),
			.n       (cnt_sat),
			.term_s1 (lane_terms[k])
		);
	end

	crc32c_merge #(
		.BYTES_PER_ITEM(BYTES_PER_ITEM)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.out_ready  (out_ready),
		.s1         (ctl_s1),
		.lane_terms (lane_terms),
		.out_valid  (out_valid),
		.crc_value  (crc_value),
		.is_last    (is_last)
	);

endmodule

// ----- hdl/crc32c_checker.sv -----
// Port-level checker for the CRC-32C stream update block, bound to its top.
// Depends only on the top level's ports.
module crc32c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [63:0] data_bytes,
	input logic [3:0]  valid_bytes,
	input logic        start_flag,
	input logic [31:0] seed_value,
	input logic        last_flag,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] crc_value,
	input logic        is_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crc_value) && $stable(is_last))
		else $error("Result changed while stalled.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled with an empty output.");

	a_seed_only: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid && start_flag && valid_bytes == 4'd0)
		##1 (!out_valid || out_ready)
		|=> out_valid && crc_value == $past(seed_value, 2) && is_last == $past(last_flag, 2))
		else $error("Seed request without bytes did not return its seed.");

	a_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid && start_flag && valid_bytes == 4'd1
			&& seed_value == 32'd0 && data_bytes[7:0] == 8'd1)
		##1 (!out_valid || out_ready)
		|=> out_valid && crc_value == 32'hF26B8303)
		else $error("Single byte CRC mismatch.");

endmodule

bind crc32c_stream_update crc32c_checker u_chk (.*);

// ----- dv/tb_crc32c_stream_update.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for crc32c_stream_update: directed and random requests with
// random gaps on both handshakes, checked against an in-bench CRC-32C predictor.
// Depends on crc32c_pkg and crc32c_stream_update.
module tb_crc32c_stream_update;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_GAP     = 16;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		crc32c_pkg::crc_t crc;
		logic             last;
	} crc_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] data_bytes;
	logic [3:0]  valid_bytes;
	logic        start_flag;
	logic [31:0] seed_value;
	logic        last_flag;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] crc_value;
	logic        is_last;

	crc_result_t      pending_results[$];
	crc32c_pkg::crc_t running_crc_shadow;
	bit               gaps_on;
	int               requests_sent;
	int               results_checked;
	int               messages_sent;
	int               error_count;
	int               cycle_count;

	crc32c_stream_update dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_bytes (data_bytes),
		.valid_bytes(valid_bytes),
		.start_flag (start_flag),
		.seed_value (seed_value),
		.last_flag  (last_flag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.crc_value  (crc_value),
		.is_last    (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic crc32c_pkg::crc_t crc32c_fold(crc32c_pkg::crc_t start_crc,
		logic [63:0] data, crc32c_pkg::cnt_t cnt);
		crc32c_pkg::crc_t c;
		int               n;
		c = start_crc;
		n = (cnt > crc32c_pkg::BYTES_DEF) ? crc32c_pkg::BYTES_DEF : int'(cnt);
		for (int b = 0; b < n; b++) begin
			c = c ^ crc32c_pkg::crc_t'(data[8*b +: 8]);
			for (int s = 0; s < 8; s++) begin
				c = c[0] ? ((c >> 1) ^ crc32c_pkg::CRC_POLY) : (c >> 1);
			end
		end
		return c;
	endfunction

	function automatic int draw_gap();
		return gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
	endfunction

	function automatic crc32c_pkg::cnt_t pick_count();
		int roll;
		roll = $urandom_range(15, 0);
		if (roll == 0) begin
			return crc32c_pkg::cnt_t'(0);
		end else if (roll == 1) begin
			return crc32c_pkg::cnt_t'($urandom_range(15, 9));
		end
		return crc32c_pkg::cnt_t'($urandom_range(8, 1));
	endfunction

	// Predict each accepted request, then check each accepted result.
	always @(posedge clk) begin
		crc_result_t      want;
		crc32c_pkg::crc_t base;
		if (arst_n && in_valid && in_ready) begin
			base = start_flag ? seed_value : running_crc_shadow;
			running_crc_shadow = crc32c_fold(base, data_bytes, valid_bytes);
			want.crc  = running_crc_shadow;
			want.last = last_flag;
			pending_results.push_back(want);
			requests_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual crc %h last %b",
					$time, crc_value, is_last);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (crc_value !== want.crc) begin
					$display("%0t: crc_value mismatch, expected %h, actual %h",
						$time, want.crc, crc_value);
					error_count++;
				end
				if (is_last !== want.last) begin
					$display("%0t: is_last mismatch, expected %b, actual %b",
						$time, want.last, is_last);
					error_count++;
				end
				results_checked++;
			end
		end
	end

	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_request(input logic [63:0] data, input crc32c_pkg::cnt_t cnt,
		input logic start, input crc32c_pkg::crc_t seed, input logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_bytes  <= data;
		valid_bytes <= cnt;
		start_flag  <= start;
		seed_value  <= seed;
		last_flag   <= last;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() > 0);
	endtask

	task automatic send_message(input int len, input bit broken);
		logic start;
		logic last;
		for (int k = 0; k < len; k++) begin
			start = (k == 0);
			last  = (k == len - 1);
			if (broken && ($urandom_range(3, 0) == 0)) begin
				start = 1'($urandom_range(1, 0));
				last  = 1'($urandom_range(1, 0));
			end
			send_request({$urandom(), $urandom()}, pick_count(), start, $urandom(), last);
		end
		messages_sent++;
	endtask

	task automatic test_directed();
		send_request(64'h0, crc32c_pkg::cnt_t'(8), 1'b1, 32'h0, 1'b0);
		send_request('1, crc32c_pkg::cnt_t'(8), 1'b0, 32'h0, 1'b0);
		send_request('1, crc32c_pkg::cnt_t'(8), 1'b1, '1, 1'b1);
		// A zero count returns the seed, or the stored CRC without a start.
		send_request({$urandom(), $urandom()}, crc32c_pkg::cnt_t'(0), 1'b1, '1, 1'b0);
		send_request({$urandom(), $urandom()}, crc32c_pkg::cnt_t'(0), 1'b0, 32'h1234_5678,
			1'b1);
		send_request(64'h3837_3635_3433_3231, crc32c_pkg::cnt_t'(8), 1'b1, 32'h0, 1'b0);
		send_request(64'hFFFF_FFFF_FFFF_FF39, crc32c_pkg::cnt_t'(1), 1'b0, '1, 1'b1);
		// The last flag leaves the stored CRC in place for the next request.
		send_request({$urandom(), $urandom()}, crc32c_pkg::cnt_t'(4), 1'b0, '1, 1'b0);
		for (int c = 9; c <= 15; c++) begin
			send_request({$urandom(), $urandom()}, crc32c_pkg::cnt_t'(c), 1'b0, 32'h0,
				c == 15);
		end
		for (int c = 1; c <= 7; c++) begin
			send_request({8{8'hA5 ^ 8'(c)}}, crc32c_pkg::cnt_t'(c), c == 1, 32'h8000_0001,
				c == 7);
		end
		messages_sent += 6;
	endtask

	task automatic test_messages(input int target, input bit broken);
		int stop_at;
		stop_at = requests_sent + target;
		while (requests_sent < stop_at) begin
			send_message($urandom_range(12, 1), broken && ($urandom_range(9, 0) == 0));
		end
	endtask

	task automatic test_back_to_back(input int target);
		gaps_on = 1'b0;
		test_messages(target, 1'b0);
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_until_drained();
		test_messages(40, 1'b0);
		hold_until_drained();
		test_messages(40, 1'b0);
	endtask

	task automatic test_noise(input int target);
		for (int k = 0; k < target; k++) begin
			send_request({$urandom(), $urandom()},
				crc32c_pkg::cnt_t'($urandom_range(15, 0)),
				1'($urandom_range(1, 0)), $urandom(), 1'($urandom_range(1, 0)));
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_bytes  <= '0;
		valid_bytes <= '0;
		start_flag  <= 1'b0;
		seed_value  <= '0;
		last_flag   <= 1'b0;
		running_crc_shadow = '0;
		gaps_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_messages(600, 1'b1);
		test_back_to_back(300);
		test_pause_until_drained();
		test_noise(250);
		test_messages(350, 1'b1);

		hold_until_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Checked %0d results from %0d requests in about %0d messages,", results_checked,
			requests_sent, messages_sent);
		$display("with byte counts 0 to 15, seeded and continued CRCs, and gaps of 0 to 16.");
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/crc32c_pkg.sv
hdl/crc32c_lane.sv
hdl/crc32c_merge.sv
hdl/crc32c_stream_update.sv
hdl/crc32c_checker.sv
dv/tb_crc32c_stream_update.sv
